### sv/tliq_pkg.sv
// ---------------------------------------------------------------------------
// tliq_pkg: shared types and codes for the three-level insert queue
// Holds the command and level codes, the per-cell shift operation and the
// result flag group passed from the controller to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package tliq_pkg;

    // Command codes carried in the request
    localparam logic [1:0] CMD_ENQ = 2'd0;
    localparam logic [1:0] CMD_DEQ = 2'd1;
    localparam logic [1:0] CMD_CLR = 2'd2;

    // Urgency levels for an enqueue
    localparam logic [1:0] LVL_HIGH = 2'd0;
    localparam logic [1:0] LVL_MED  = 2'd1;
    localparam logic [1:0] LVL_LOW  = 2'd2;

    // Field widths of the stream payloads
    localparam int FIELD_W   = 32;
    localparam int COUNT_W   = 8;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // Operation broadcast to every cell of the row
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE
    } cell_op_t;

    // Status of one request
    typedef struct packed {
        logic removed;
        logic dropped;
    } rslt_flags_t;

endpackage

`default_nettype wire

### sv/tliq_cell.sv
// ---------------------------------------------------------------------------
// tliq_cell: one storage cell of the queue row
// Holds one word and, on each operation, keeps it, takes the neighbor
// toward the head, takes the neighbor toward the tail or loads a new word.
// ---------------------------------------------------------------------------
`default_nettype none

module tliq_cell
    import tliq_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 7,
    parameter int DATA_W   = 32
) (
    input  wire logic              aclk,
    input  wire cell_op_t          op,
    input  wire logic [IDX_W-1:0]  pos,
    input  wire logic [DATA_W-1:0] new_word,
    input  wire logic [DATA_W-1:0] head_side_word,
    input  wire logic [DATA_W-1:0] tail_side_word,
    output logic      [DATA_W-1:0] word
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [DATA_W-1:0] word_reg;
    logic [DATA_W-1:0] word_next;

    // Select the next content of this cell
    always_comb begin
        word_next = word_reg;
        unique case (op)
            OP_INSERT: begin
                if (MY_IDX == pos) begin
                    word_next = new_word;
                end else if (MY_IDX > pos) begin
                    word_next = head_side_word;
                end
            end
            OP_REMOVE: begin
                word_next = tail_side_word;
            end
            default: begin
                word_next = word_reg;
            end
        endcase
    end

    // Payload storage, no reset
    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

`default_nettype wire

### sv/tliq_ctrl.sv
// ---------------------------------------------------------------------------
// tliq_ctrl: occupancy tracking and request decode
// Keeps the entry count and turns each accepted request into the operation
// and insertion index broadcast to the cell row.
// ---------------------------------------------------------------------------
`default_nettype none

module tliq_ctrl
    import tliq_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int IDX_W = 7,
    parameter int CNT_W = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             accept,
    input  wire logic [1:0]       cmd,
    input  wire logic [1:0]       level,
    output cell_op_t              op,
    output logic      [IDX_W-1:0] pos,
    output rslt_flags_t           flags,
    output logic      [CNT_W-1:0] occ_after
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;
    logic [CNT_W-1:0] mid_half;
    logic [CNT_W-1:0] mid_pos;

    // Middle index: max(1, (n-1)/2), or 0 on an empty queue
    always_comb begin
        mid_half = (occ_reg - ONE_CNT) >> 1;
        if (occ_reg == '0) begin
            mid_pos = '0;
        end else if (mid_half == '0) begin
            mid_pos = ONE_CNT;
        end else begin
            mid_pos = mid_half;
        end
    end

    // Decode the request
    always_comb begin
        op       = OP_HOLD;
        pos      = '0;
        flags    = '0;
        occ_next = occ_reg;
        if (accept) begin
            unique case (cmd)
                CMD_ENQ: begin
                    if (occ_reg == FULL_CNT) begin
                        flags.dropped = 1'b1;
                    end else begin
                        priority if (level == LVL_HIGH) begin
                            op       = OP_INSERT;
                            pos      = '0;
                            occ_next = occ_reg + ONE_CNT;
                        end else if (level == LVL_MED) begin
                            op       = OP_INSERT;
                            pos      = mid_pos[IDX_W-1:0];
                            occ_next = occ_reg + ONE_CNT;
                        end else if (level == LVL_LOW) begin
                            op       = OP_INSERT;
                            pos      = occ_reg[IDX_W-1:0];
                            occ_next = occ_reg + ONE_CNT;
                        end else begin
                            op = OP_HOLD;
                        end
                    end
                end
                CMD_DEQ: begin
                    if (occ_reg != '0) begin
                        op            = OP_REMOVE;
                        flags.removed = 1'b1;
                        occ_next      = occ_reg - ONE_CNT;
                    end
                end
                CMD_CLR: begin
                    occ_next = '0;
                end
                default: begin
                    occ_next = occ_reg;
                end
            endcase
        end
    end

    // Entry count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    assign occ_after = occ_next;

endmodule

`default_nettype wire

### sv/three_level_insert_queue.sv
// ---------------------------------------------------------------------------
// three_level_insert_queue: ordered buffer with urgency-based insertion
// Top level: request decode, the row of storage cells and the result
// register on the output stream.
// ---------------------------------------------------------------------------
// A new request (enqueue, dequeue or clear) is accepted every cycle while
// the output side keeps up, and its result appears in the output register
// on the following cycle. The row of DEPTH cells shifts the entries behind
// the insertion index toward the tail on an enqueue, or every entry toward
// the head on a dequeue. Every request gives exactly one result; a full
// queue refuses an enqueue and flags it as dropped.
`default_nettype none

module three_level_insert_queue
    import tliq_pkg::*;
#(
    parameter int DEPTH  = 128,
    parameter int DATA_W = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [1:0] cmd, [3:2] level, [35:4] data_in, [39:36] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [31:0] data_out, [32] out_valid, [33] dropped, [41:34] count, [47:42] zero
    output logic      [M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic              accept;
    logic [1:0]        cmd;
    logic [1:0]        level;
    logic [63:0]       word_wide;
    logic [DATA_W-1:0] new_word;
    cell_op_t          op;
    logic [IDX_W-1:0]  pos;
    rslt_flags_t       flags;
    logic [CNT_W-1:0]  occ_after;
    logic [DATA_W-1:0] cell_word [DEPTH];
    logic [63:0]       head_wide;
    logic [FIELD_W-1:0] data_out;
    logic [31:0]       count_wide;

    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;

    // Unpack the request
    assign cmd       = s_tdata[1:0];
    assign level     = s_tdata[3:2];
    assign word_wide = {32'd0, s_tdata[35:4]};
    assign new_word  = word_wide[DATA_W-1:0];

    // Accept while the result register is free or being drained
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    tliq_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .cmd       (cmd),
        .level     (level),
        .op        (op),
        .pos       (pos),
        .flags     (flags),
        .occ_after (occ_after)
    );

    // Row of cells; the ends wrap back onto themselves
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] head_side;
        logic [DATA_W-1:0] tail_side;

        if (i == 0) begin : g_first
            assign head_side = cell_word[i];
        end else begin : g_inner_h
            assign head_side = cell_word[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign tail_side = cell_word[i];
        end else begin : g_inner_t
            assign tail_side = cell_word[i+1];
        end

        tliq_cell #(
            .CELL_IDX (i),
            .IDX_W    (IDX_W),
            .DATA_W   (DATA_W)
        ) u_cell (
            .aclk           (aclk),
            .op             (op),
            .pos            (pos),
            .new_word       (new_word),
            .head_side_word (head_side),
            .tail_side_word (tail_side),
            .word           (cell_word[i])
        );
    end

    // Form the result of this request
    assign head_wide  = 64'(cell_word[0]);
    assign data_out   = flags.removed ? head_wide[FIELD_W-1:0] : '0;
    assign count_wide = 32'(occ_after);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'd0, count_wide[COUNT_W-1:0], flags.dropped,
                             flags.removed, data_out};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
